// ===== rtl/core/sed_pkg.sv =====
// shared types and constants for the speech endpoint detector core
// used by the front, queue, back and top-level modules; depends on nothing
package sed_pkg;

	localparam int DATA_W    = 16;
	localparam int SUM_W     = 28;
	localparam int CFG_IDX_W = 3;

	localparam int MAX_CHUNK_SAMPLES_DEF = 4096;
	localparam int QUEUE_DEPTH_DEF       = 4;

	localparam logic [DATA_W-1:0] SILENCE_TIMEOUT_RST   = 16'd450;
	localparam logic [DATA_W-1:0] NO_SPEECH_TIMEOUT_RST = 16'd5000;
	localparam logic [DATA_W-1:0] MAX_SESSION_RST       = 16'd15000;
	localparam logic [DATA_W-1:0] MEAN_ABS_THR_RST      = 16'd350;
	localparam logic [DATA_W-1:0] PEAK_THR_RST          = 16'd1200;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_START  = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SILENCE,
		CFG_NO_SPEECH,
		CFG_MAX_SESSION,
		CFG_MEAN_THR,
		CFG_PEAK_THR
	} cfg_idx_t;

	typedef enum logic [2:0] {
		R_NONE,
		R_MAX_DURATION,
		R_IDLE_NO_SPEECH,
		R_IDLE_SILENCE,
		R_POST_SILENCE,
		R_NO_SPEECH_WIN
	} reason_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE,
		KIND_TICK,
		KIND_START
	} kind_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [DATA_W-1:0]     data;
	} cfg_wr_t;

	typedef struct packed {
		kind_t             kind;
		logic [DATA_W-1:0] mag;
		logic              last;
	} queue_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== rtl/core/speech_endpoint_detector_core.sv =====
// Energy-based speech endpoint detector, top level.
// Input channel (in_valid / in_stall): one transaction carries opcode, sample and
// chunk_last; opcode 0 is an audio sample, 1 a millisecond tick, 2 starts a session.
// Output channel (out_valid / out_stall): at most one result per input transaction,
// reporting a finished chunk and/or a session end with its reason code.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 silence timeout,
// 1 no-speech timeout, 2 max session, 3 mean threshold, 4 peak threshold); write
// only while no transaction is in flight.
// Path: an accepted transaction waits in the input queue; the back end pops it and
// loads any result into the output register. Throughput: one transaction per cycle
// while the output does not stall, set by the state update in the back end; the
// input queue absorbs up to QUEUE_DEPTH transactions while the output side stalls.
// Reset clears all session state, empties the queue, drops any pending result and
// restores the threshold and timeout registers to their defaults.
// While out_stall is high the pending result holds and the back end stops if a
// result waits in the output register; in_stall rises when the queue fills.
// Depends on sed_pkg, sed_front, sed_queue and sed_back.
module speech_endpoint_detector_core import sed_pkg::*; #(
	parameter int MAX_CHUNK_SAMPLES = MAX_CHUNK_SAMPLES_DEF,
	parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               opcode,
	input  logic signed [DATA_W-1:0] sample,
	input  logic                     chunk_last,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     chunk_done,
	output logic                     chunk_is_speech,
	output logic                     session_ended,
	output logic [2:0]               end_reason,
	output logic                     no_audio_sent,
	output logic [DATA_W-1:0]        chunks_counted
);

	cfg_wr_t      cfg;
	q_status_t    q_status;
	logic         push, pop;
	queue_entry_t push_entry, pop_entry;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	sed_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.sample     (sample),
		.chunk_last (chunk_last),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	sed_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.status     (q_status)
	);

	sed_back #(
		.MAX_CHUNK_SAMPLES (MAX_CHUNK_SAMPLES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.q_status        (q_status),
		.entry           (pop_entry),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.chunk_done      (chunk_done),
		.chunk_is_speech (chunk_is_speech),
		.session_ended   (session_ended),
		.end_reason      (end_reason),
		.no_audio_sent   (no_audio_sent),
		.chunks_counted  (chunks_counted)
	);

endmodule

// ===== rtl/core/sed_front.sv =====
// front end: accepts input transactions, decodes the opcode and takes the magnitude
// of the sample; depends on sed_pkg
module sed_front import sed_pkg::*; (
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        opcode,
	input  logic signed [DATA_W-1:0] sample,
	input  logic              chunk_last,
	input  q_status_t         q_status,
	output logic              push,
	output queue_entry_t      push_entry
);

	logic              accept;
	logic              known_op;
	kind_t             kind;
	logic [DATA_W-1:0] raw;

	assign in_stall = q_status.full;
	assign accept   = in_valid && !q_status.full;
	assign raw      = DATA_W'(sample);

	always_comb begin
		known_op = 1'b1;
		kind     = KIND_SAMPLE;
		unique case (opcode)
			OP_SAMPLE: kind = KIND_SAMPLE;
			OP_TICK:   kind = KIND_TICK;
			OP_START:  kind = KIND_START;
			default:   known_op = 1'b0;
		endcase
	end

	// undefined opcode is swallowed here and never reaches the back end
	assign push = accept && known_op;

	assign push_entry.kind = kind;
	// most negative sample maps to 0x8000, which still fits unsigned
	assign push_entry.mag  = raw[DATA_W-1] ? (~raw + DATA_W'(1)) : raw;
	assign push_entry.last = chunk_last;

endmodule

// ===== rtl/core/sed_queue.sv =====
// short fifo of decoded transactions between front and back end
// depends on sed_pkg for the entry and status types
module sed_queue import sed_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  queue_entry_t push_entry,
	input  logic         pop,
	output queue_entry_t pop_entry,
	output q_status_t    status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	queue_entry_t     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign pop_entry    = mem_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_FULL);
	assign status.empty = (count_q == '0);

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue fill count above depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/core/sed_back.sv =====
// back end: configuration registers, session and chunk state, and the result register
// depends on sed_pkg
module sed_back import sed_pkg::*; #(
	parameter int MAX_CHUNK_SAMPLES = MAX_CHUNK_SAMPLES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_wr_t           cfg,
	input  q_status_t         q_status,
	input  queue_entry_t      entry,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              chunk_done,
	output logic              chunk_is_speech,
	output logic              session_ended,
	output logic [2:0]        end_reason,
	output logic              no_audio_sent,
	output logic [DATA_W-1:0] chunks_counted
);

	localparam int CNT_W = $clog2(MAX_CHUNK_SAMPLES + 1);
	localparam int THR_W = DATA_W + CNT_W;
	localparam int CMP_W = (THR_W > SUM_W) ? THR_W : SUM_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHUNK_SAMPLES);

	// configuration
	logic [DATA_W-1:0] silence_q, no_speech_q, max_session_q, mean_thr_q, peak_thr_q;

	// session and chunk state
	logic              active_q, active_d;
	logic              heard_q, heard_d;
	logic [DATA_W-1:0] elapsed_q, elapsed_d;
	logic [DATA_W-1:0] last_speech_q, last_speech_d;
	logic [DATA_W-1:0] chunk_cnt_q, chunk_cnt_d;
	logic [SUM_W-1:0]  sum_q, sum_d;
	logic [DATA_W-1:0] peak_q, peak_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;

	// result register
	logic              out_valid_q;
	logic              done_q, speech_q, no_audio_q;
	reason_t           reason_q;
	logic [DATA_W-1:0] counted_q;

	logic              res_valid, res_done, res_speech;
	reason_t           res_reason;
	logic [DATA_W-1:0] elapsed_inc, since_tick, since_now, chunk_inc;
	logic [SUM_W:0]    sum_add;
	logic [SUM_W-1:0]  sum_new;
	logic [DATA_W-1:0] peak_new;
	logic [CNT_W-1:0]  cnt_new;
	logic [THR_W-1:0]  thr_new;
	logic              cnt_room, is_speech, closing;

	assign pop = !q_status.empty && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			silence_q     <= SILENCE_TIMEOUT_RST;
			no_speech_q   <= NO_SPEECH_TIMEOUT_RST;
			max_session_q <= MAX_SESSION_RST;
			mean_thr_q    <= MEAN_ABS_THR_RST;
			peak_thr_q    <= PEAK_THR_RST;
		end else if (cfg.we) begin
			unique case (cfg.index)
				CFG_SILENCE:     silence_q     <= cfg.data;
				CFG_NO_SPEECH:   no_speech_q   <= cfg.data;
				CFG_MAX_SESSION: max_session_q <= cfg.data;
				CFG_MEAN_THR:    mean_thr_q    <= cfg.data;
				CFG_PEAK_THR:    peak_thr_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + DATA_W'(1);
	assign since_tick  = (elapsed_inc >= last_speech_q) ? elapsed_inc - last_speech_q : '0;
	assign since_now   = (elapsed_q >= last_speech_q) ? elapsed_q - last_speech_q : '0;
	assign chunk_inc   = (chunk_cnt_q == '1) ? chunk_cnt_q : chunk_cnt_q + DATA_W'(1);

	assign sum_add   = {1'b0, sum_q} + (SUM_W + 1)'(entry.mag);
	assign sum_new   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
	assign peak_new  = (entry.mag > peak_q) ? entry.mag : peak_q;
	assign cnt_room  = (cnt_q < CNT_MAX);
	assign cnt_new   = cnt_room ? cnt_q + CNT_W'(1) : cnt_q;
	// mean threshold times sample count, the integer form of the mean test
	assign thr_new   = THR_W'(mean_thr_q) * THR_W'(cnt_new);
	assign is_speech = (CMP_W'(sum_new) >= CMP_W'(thr_new)) || (peak_new >= peak_thr_q);
	assign closing   = entry.last || (cnt_new == CNT_MAX);

	always_comb begin
		active_d      = active_q;
		heard_d       = heard_q;
		elapsed_d     = elapsed_q;
		last_speech_d = last_speech_q;
		chunk_cnt_d   = chunk_cnt_q;
		sum_d         = sum_q;
		peak_d        = peak_q;
		cnt_d         = cnt_q;
		res_valid     = 1'b0;
		res_done      = 1'b0;
		res_speech    = 1'b0;
		res_reason    = R_NONE;

		if (pop) begin
			unique case (entry.kind)
				KIND_START: begin
					active_d      = 1'b1;
					heard_d       = 1'b0;
					elapsed_d     = '0;
					last_speech_d = '0;
					chunk_cnt_d   = '0;
					sum_d         = '0;
					peak_d        = '0;
					cnt_d         = '0;
				end
				KIND_TICK: begin
					if (active_q) begin
						elapsed_d = elapsed_inc;
						if (elapsed_inc >= max_session_q) begin
							res_reason = R_MAX_DURATION;
						end else if (!heard_q && elapsed_inc >= no_speech_q) begin
							res_reason = R_IDLE_NO_SPEECH;
						end else if (heard_q && since_tick >= silence_q) begin
							res_reason = R_IDLE_SILENCE;
						end
						res_valid = (res_reason != R_NONE);
					end
				end
				KIND_SAMPLE: begin
					if (active_q) begin
						if (closing) begin
							res_valid = 1'b1;
							sum_d     = '0;
							peak_d    = '0;
							cnt_d     = '0;
							if (elapsed_q >= max_session_q) begin
								// chunk dropped uncounted when the session is over time
								res_reason = R_MAX_DURATION;
							end else begin
								chunk_cnt_d = chunk_inc;
								res_done    = 1'b1;
								res_speech  = is_speech;
								if (is_speech) begin
									heard_d       = 1'b1;
									last_speech_d = elapsed_q;
								end else if (heard_q && since_now >= silence_q) begin
									res_reason = R_POST_SILENCE;
								end else if (!heard_q && elapsed_q >= no_speech_q) begin
									res_reason = R_NO_SPEECH_WIN;
								end
							end
						end else begin
							sum_d  = sum_new;
							peak_d = peak_new;
							cnt_d  = cnt_new;
						end
					end
				end
				default: ;
			endcase

			if (res_reason != R_NONE) begin
				active_d = 1'b0;
				sum_d    = '0;
				peak_d   = '0;
				cnt_d    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			heard_q       <= 1'b0;
			elapsed_q     <= '0;
			last_speech_q <= '0;
			chunk_cnt_q   <= '0;
			sum_q         <= '0;
			peak_q        <= '0;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			active_q      <= active_d;
			heard_q       <= heard_d;
			elapsed_q     <= elapsed_d;
			last_speech_q <= last_speech_d;
			chunk_cnt_q   <= chunk_cnt_d;
			sum_q         <= sum_d;
			peak_q        <= peak_d;
			cnt_q         <= cnt_d;
			if (res_valid) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			done_q     <= res_done;
			speech_q   <= res_speech;
			reason_q   <= res_reason;
			no_audio_q <= (res_reason != R_NONE) && (chunk_cnt_d == '0);
			counted_q  <= chunk_cnt_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign chunk_done      = done_q;
	assign chunk_is_speech = speech_q;
	assign session_ended   = (reason_q != R_NONE);
	assign end_reason      = reason_q;
	assign no_audio_sent   = no_audio_q;
	assign chunks_counted  = counted_q;

`ifndef ASSERT_OFF
	a_overtime_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && reason_q == R_MAX_DURATION) |-> !done_q)
		else $error("over-time chunk reported as done");
	a_no_audio_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && no_audio_q) |-> (counted_q == '0 && reason_q != R_NONE))
		else $error("no-audio flag without ended empty session");
	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !done_q) |-> (reason_q != R_NONE))
		else $error("result with neither chunk nor session end");
`endif

endmodule

// ===== dv/speech_endpoint_detector_core_tb.sv =====
// self-checking testbench for speech_endpoint_detector_core: chunk classification,
// session timeouts and end reasons against a cycle-free model of the endpointing rules
// depends on sed_pkg and the speech_endpoint_detector_core rtl
module speech_endpoint_detector_core_tb import sed_pkg::*; ();

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         CHUNK_MAX   = MAX_CHUNK_SAMPLES_DEF;
	localparam longint     SUM_LIMIT   = longint'(2) ** SUM_W - 1;
	localparam int         SETTLE      = QUEUE_DEPTH_DEF + 8;
	localparam int         N_PHASES    = 12;
	localparam int         PHASE_ITEMS = 140;
	localparam int         CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [1:0]        op;
		logic [DATA_W-1:0] smp;
		logic              last;
	} audio_item_t;

	typedef struct packed {
		logic              done;
		logic              speech;
		logic              ended;
		reason_t           reason;
		logic              no_audio;
		logic [DATA_W-1:0] count;
	} endpoint_report_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [DATA_W-1:0]        cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [1:0]               opcode = OP_START;
	logic signed [DATA_W-1:0] sample = '0;
	logic                     chunk_last = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     chunk_done;
	logic                     chunk_is_speech;
	logic                     session_ended;
	logic [2:0]               end_reason;
	logic                     no_audio_sent;
	logic [DATA_W-1:0]        chunks_counted;

	audio_item_t      pending_items[$];
	endpoint_report_t reports_due[$];
	int               items_queued = 0;
	int               items_accepted = 0;
	int               fail_count = 0;

	// register copies
	logic [DATA_W-1:0] silence_to  = SILENCE_TIMEOUT_RST;
	logic [DATA_W-1:0] nospeech_to = NO_SPEECH_TIMEOUT_RST;
	logic [DATA_W-1:0] max_ms      = MAX_SESSION_RST;
	logic [DATA_W-1:0] mean_thr    = MEAN_ABS_THR_RST;
	logic [DATA_W-1:0] peak_thr    = PEAK_THR_RST;

	// session and chunk state
	logic              sess_on = 1'b0;
	logic              heard = 1'b0;
	logic [DATA_W-1:0] elapsed = '0;
	logic [DATA_W-1:0] last_speech = '0;
	logic [DATA_W-1:0] chunk_cnt = '0;
	logic [SUM_W-1:0]  acc_sum = '0;
	logic [DATA_W-1:0] acc_peak = '0;
	logic [12:0]       acc_count = '0;

	// driver and receiver pacing
	audio_item_t      cur_item;
	endpoint_report_t cur_report;
	logic             got_report;
	int               burst_left = 16;
	int               gap_left = 0;
	int               hold_left = 0;
	int               stall_span = 0;
	int               stall_pct = 0;
	bit               long_hold_req = 1'b0;
	bit               long_hold_done = 1'b0;

	speech_endpoint_detector_core dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic clear_chunk();
		acc_sum = '0;
		acc_peak = '0;
		acc_count = '0;
	endtask

	task automatic update_endpoint_state(input audio_item_t it, output logic has,
			output endpoint_report_t rep);
		reason_t    why;
		int         mag;
		int         since;
		longint     total;
		logic       spk;
		has = 1'b0;
		rep = '0;
		why = R_NONE;
		case (it.op)
		OP_START: begin
			sess_on = 1'b1;
			heard = 1'b0;
			elapsed = '0;
			last_speech = '0;
			chunk_cnt = '0;
			clear_chunk();
		end
		OP_TICK: begin
			if (sess_on) begin
				if (elapsed != '1)
					elapsed++;
				since = (elapsed >= last_speech) ? int'(elapsed - last_speech) : 0;
				if (elapsed >= max_ms)
					why = R_MAX_DURATION;
				else if (!heard && elapsed >= nospeech_to)
					why = R_IDLE_NO_SPEECH;
				else if (heard && since >= int'(silence_to))
					why = R_IDLE_SILENCE;
				has = (why != R_NONE);
			end
		end
		OP_SAMPLE: begin
			if (sess_on) begin
				mag = $signed(it.smp);
				if (mag < 0)
					mag = -mag;
				total = longint'(acc_sum) + mag;
				acc_sum = (total > SUM_LIMIT) ? SUM_LIMIT[SUM_W-1:0] : total[SUM_W-1:0];
				if (mag > int'(acc_peak))
					acc_peak = DATA_W'(mag);
				if (acc_count < CHUNK_MAX)
					acc_count++;
				if (it.last || acc_count >= CHUNK_MAX) begin
					has = 1'b1;
					if (elapsed >= max_ms) begin
						// session over before the chunk is counted
						why = R_MAX_DURATION;
					end else begin
						if (chunk_cnt != '1)
							chunk_cnt++;
						spk = (longint'(acc_sum) >= longint'(mean_thr) * longint'(acc_count))
							|| (acc_peak >= peak_thr);
						since = (elapsed >= last_speech) ? int'(elapsed - last_speech) : 0;
						if (spk) begin
							heard = 1'b1;
							last_speech = elapsed;
						end else if (heard && since >= int'(silence_to)) begin
							why = R_POST_SILENCE;
						end else if (!heard && elapsed >= nospeech_to) begin
							why = R_NO_SPEECH_WIN;
						end
						rep.done = 1'b1;
						rep.speech = spk;
					end
					clear_chunk();
				end
			end
		end
		default: ;
		endcase
		if (has) begin
			rep.ended = (why != R_NONE);
			rep.reason = why;
			rep.no_audio = rep.ended && (chunk_cnt == '0);
			rep.count = chunk_cnt;
			if (rep.ended) begin
				sess_on = 1'b0;
				clear_chunk();
			end
		end
	endtask

	task automatic push(input logic [1:0] op, input logic [DATA_W-1:0] smp, input logic last);
		audio_item_t it;
		it.op = op;
		it.smp = smp;
		it.last = last;
		pending_items.push_back(it);
		items_queued++;
	endtask

	function automatic logic [DATA_W-1:0] gen_sample(input int level);
		int mag;
		case (level)
		0: mag = $urandom_range(0, 400);
		1: mag = $urandom_range(300, 1500);
		2: return DATA_W'($urandom);
		3: begin
			case ($urandom_range(0, 4))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'h0001;
			endcase
		end
		default: mag = $urandom_range(0, 700);
		endcase
		return $urandom_range(0, 1) ? DATA_W'(-mag) : DATA_W'(mag);
	endfunction

	function automatic logic [DATA_W-1:0] rand_timeout();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		default: return DATA_W'($urandom_range(1, 40));
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] rand_threshold();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return 16'd32768;
		2: return '1;
		default: return DATA_W'($urandom_range(50, 2000));
		endcase
	endfunction

	// only called while nothing is in flight
	task automatic set_config(input logic [DATA_W-1:0] sil, input logic [DATA_W-1:0] nsp,
			input logic [DATA_W-1:0] mx, input logic [DATA_W-1:0] mthr,
			input logic [DATA_W-1:0] pthr);
		silence_to = sil;
		nospeech_to = nsp;
		max_ms = mx;
		mean_thr = mthr;
		peak_thr = pthr;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SILENCE;
		cfg_data <= sil;
		@(posedge clk);
		cfg_index <= CFG_NO_SPEECH;
		cfg_data <= nsp;
		@(posedge clk);
		cfg_index <= CFG_MAX_SESSION;
		cfg_data <= mx;
		@(posedge clk);
		cfg_index <= CFG_MEAN_THR;
		cfg_data <= mthr;
		@(posedge clk);
		cfg_index <= CFG_PEAK_THR;
		cfg_data <= pthr;
		// index past the last register must be dropped
		@(posedge clk);
		cfg_index <= CFG_IDX_W'(int'(CFG_PEAK_THR) + $urandom_range(1, 3));
		cfg_data <= DATA_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (items_accepted != items_queued || reports_due.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic gen_session();
		int noise;
		int n_chunks;
		int n_smp;
		int level;
		noise = $urandom_range(0, 9);
		if (noise == 0)
			push(OP_UNUSED, DATA_W'($urandom), 1'($urandom));
		if (noise != 1)
			push(OP_START, DATA_W'($urandom), 1'($urandom));
		n_chunks = $urandom_range(1, 8);
		for (int c = 0; c < n_chunks; c++) begin
			repeat ($urandom_range(0, 3)) push(OP_TICK, DATA_W'($urandom), 1'($urandom));
			n_smp = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 6);
			level = $urandom_range(0, 3);
			// noise 2 leaves the final chunk open
			for (int s = 0; s < n_smp; s++)
				push(OP_SAMPLE, gen_sample(level),
					s == n_smp - 1 && !(noise == 2 && c == n_chunks - 1));
		end
		repeat ($urandom_range(0, 12)) push(OP_TICK, DATA_W'($urandom), 1'($urandom));
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				update_endpoint_state(cur_item, got_report, cur_report);
				if (got_report)
					reports_due.push_back(cur_report);
				items_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					cur_item = pending_items.pop_front();
					opcode <= cur_item.op;
					sample <= cur_item.smp;
					chunk_last <= cur_item.last;
					in_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern, with long hold-offs to back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (long_hold_req && !long_hold_done) begin
				hold_left = 300;
				long_hold_done = 1'b1;
			end else if (hold_left == 0 && $urandom_range(0, 2999) == 0) begin
				hold_left = $urandom_range(50, 200);
			end
			if (stall_span == 0) begin
				stall_span = 64;
				case ($urandom_range(0, 4))
				0, 1: stall_pct = 0;
				2: stall_pct = 25;
				3: stall_pct = 50;
				default: stall_pct = 90;
				endcase
			end
			stall_span--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (reports_due.size() == 0) begin
				$error("result transaction with nothing outstanding");
				fail_count++;
			end else begin
				cur_report = reports_due.pop_front();
				check_field("chunk_done", DATA_W'(cur_report.done), DATA_W'(chunk_done));
				check_field("chunk_is_speech", DATA_W'(cur_report.speech),
					DATA_W'(chunk_is_speech));
				check_field("session_ended", DATA_W'(cur_report.ended), DATA_W'(session_ended));
				check_field("end_reason", DATA_W'(cur_report.reason), DATA_W'(end_reason));
				check_field("no_audio_sent", DATA_W'(cur_report.no_audio),
					DATA_W'(no_audio_sent));
				check_field("chunks_counted", cur_report.count, chunks_counted);
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$error("run exceeded %0d cycles", CYCLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int phase_start;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset register values: ignored items, threshold edges, restart
		push(OP_SAMPLE, 16'd100, 1'b1);
		push(OP_TICK, 16'h0000, 1'b0);
		push(OP_UNUSED, 16'hFFFF, 1'b1);
		push(OP_START, 16'h0000, 1'b0);
		push(OP_SAMPLE, 16'd350, 1'b1);
		push(OP_SAMPLE, -16'sd349, 1'b1);
		push(OP_SAMPLE, 16'd1200, 1'b0);
		repeat (3) push(OP_SAMPLE, 16'd0, 1'b0);
		push(OP_SAMPLE, 16'd0, 1'b1);
		push(OP_SAMPLE, -16'sd1199, 1'b0);
		repeat (2) push(OP_SAMPLE, 16'd0, 1'b0);
		push(OP_SAMPLE, 16'd0, 1'b1);
		push(OP_SAMPLE, 16'h7FFF, 1'b1);
		push(OP_SAMPLE, 16'h8000, 1'b1);
		repeat (3) push(OP_TICK, 16'hFFFF, 1'b1);
		push(OP_UNUSED, 16'h0000, 1'b0);
		push(OP_START, 16'hFFFF, 1'b1);
		push(OP_SAMPLE, 16'd0, 1'b1);
		push(OP_SAMPLE, 16'hFFFF, 1'b0);
		push(OP_SAMPLE, 16'd1, 1'b1);
		drain();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
			0: set_config(16'd3, 16'd6, 16'd25, 16'd350, 16'd1200);
			1: set_config(16'd0, 16'd0, 16'd30, 16'd350, 16'd1200);
			2: set_config('0, '0, '0, '0, '0);
			3: set_config('1, '1, '1, '1, '1);
			4: set_config(16'd1, 16'd1, 16'd2, 16'd32768, 16'd32768);
			default: set_config(rand_timeout(), rand_timeout(), rand_timeout(),
				rand_threshold(), rand_threshold());
			endcase
			phase_start = items_queued;
			while (items_queued - phase_start < PHASE_ITEMS)
				gen_session();
			if (ph == 0) begin
				@(negedge clk);
				long_hold_req = 1'b1;
			end
			drain();
		end

		// one chunk long enough to be closed by the sample limit, then a short one
		set_config(16'd450, 16'd5000, '1, 16'd350, '1);
		push(OP_START, 16'h0000, 1'b0);
		for (int s = 0; s < CHUNK_MAX + 3; s++)
			push(OP_SAMPLE, gen_sample(4), s == CHUNK_MAX + 2);
		drain();

		if (fail_count == 0 && reports_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
